FILE: hdl/lcta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcta_pkg: shared types and constants of the template averager
// Field widths, default sizes, command and back-end state encodings.
// ----------------------------------------------------------------------------
package lcta_pkg;

    // default store geometry
    localparam int LABELS_DEF   = 32;
    localparam int CHANNELS_DEF = 8;
    localparam int CLIP_LEN_DEF = 64;

    // field and store widths
    localparam int LABEL_W   = 6;
    localparam int CHANNEL_W = 3;
    localparam int TIME_W    = 6;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 24;
    localparam int MEAN_W    = 16;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        OP_ACC   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // classified command flags handed from front to back
    typedef struct packed {
        op_t  op;
        logic label_ok;
        logic cell_ok;
        logic last;
    } cmd_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_QRD,
        ST_QDIV
    } back_state_t;

endpackage

FILE: hdl/lcta_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcta_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, result truncated toward
// zero and saturated to the mean range.
// ----------------------------------------------------------------------------
module lcta_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lcta_pkg::SUM_W-1:0]   dividend,
    input  logic [lcta_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [lcta_pkg::MEAN_W-1:0]  quotient
);
    import lcta_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic                run_reg, run_next;
    logic                fin_reg, fin_next;
    logic                neg_reg;
    logic [SUM_W-1:0]    q_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [CNT_W:0]      rem_sh;
    logic [CNT_W+1:0]    diff;
    logic                ge;
    logic [SUM_W-1:0]    mag;

    // magnitude of the dividend
    assign mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

    // one restoring step
    assign rem_sh = {rem_reg, q_reg[SUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = ~diff[CNT_W+1];

    // control flags
    always_comb
    begin
        run_next = run_reg;
        fin_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
        end
        else if (run_reg && (step_reg == '0))
        begin
            run_next = 1'b0;
            fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            fin_reg <= fin_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            q_reg    <= mag;
            rem_reg  <= '0;
            den_reg  <= divisor;
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (run_reg)
        begin
            q_reg    <= {q_reg[SUM_W-2:0], ge};
            rem_reg  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // sign and saturation of the final quotient
    always_comb
    begin
        if (!neg_reg)
        begin
            if (q_reg > SUM_W'(32767))
                quotient = {1'b0, {(MEAN_W-1){1'b1}}};
            else
                quotient = q_reg[MEAN_W-1:0];
        end
        else
        begin
            if (q_reg > SUM_W'(32768))
                quotient = {1'b1, {(MEAN_W-1){1'b0}}};
            else
                quotient = MEAN_W'(~q_reg[MEAN_W-1:0] + MEAN_W'(1));
        end
    end

    assign done = fin_reg;

endmodule

FILE: hdl/lcta_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcta_front: command classifier
// Checks label and cell ranges, forms the sum store address and the count
// index, and flags accumulate words that carry no usable label as not kept.
// ----------------------------------------------------------------------------
module lcta_front #(
    parameter int MAX_LABELS   = lcta_pkg::LABELS_DEF,
    parameter int MAX_CHANNELS = lcta_pkg::CHANNELS_DEF,
    parameter int MAX_CLIP_LEN = lcta_pkg::CLIP_LEN_DEF
) (
    input  logic                           op,
    input  logic [lcta_pkg::LABEL_W-1:0]   label,
    input  logic [lcta_pkg::CHANNEL_W-1:0] channel,
    input  logic [lcta_pkg::TIME_W-1:0]    time_offset,
    input  logic                           clip_last,
    output logic                           keep,
    output lcta_pkg::cmd_ctl_t             ctl,
    output logic [((MAX_LABELS*MAX_CHANNELS*MAX_CLIP_LEN) > 1 ?
                   $clog2(MAX_LABELS*MAX_CHANNELS*MAX_CLIP_LEN) : 1)-1:0] addr,
    output logic [(MAX_LABELS > 1 ? $clog2(MAX_LABELS) : 1)-1:0] lbl_idx
);
    import lcta_pkg::*;

    localparam int CELLS  = MAX_LABELS * MAX_CHANNELS * MAX_CLIP_LEN;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LBL_IW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

    logic [8:0]        lbl_m1;
    logic [ADDR_W-1:0] row;
    logic              label_ok;
    logic              cell_ok;

    // range checks
    assign label_ok = (label != '0) && (32'(label) <= 32'(MAX_LABELS));
    assign cell_ok  = (32'(channel) < 32'(MAX_CHANNELS)) &&
                      (32'(time_offset) < 32'(MAX_CLIP_LEN));

    // label, channel, time to flat cell address
    assign lbl_m1  = 9'(label) - 9'd1;
    assign lbl_idx = lbl_m1[LBL_IW-1:0];
    assign row     = ADDR_W'(lbl_m1) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(channel);
    assign addr    = row * ADDR_W'(MAX_CLIP_LEN) + ADDR_W'(time_offset);

    // classified flags
    always_comb
    begin
        ctl.op       = op_t'(op);
        ctl.label_ok = label_ok;
        ctl.cell_ok  = cell_ok;
        ctl.last     = clip_last;
        keep         = (op_t'(op) == OP_QUERY) || label_ok;
    end

endmodule

FILE: hdl/lcta_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcta_fifo: short command queue
// Register-based circular queue that decouples the classifier from the
// store sequencer.
// ----------------------------------------------------------------------------
module lcta_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lcta_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              not_empty,
    output logic              full
);
    import lcta_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

    assign dout      = mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CNT_W'(DEPTH));

endmodule

FILE: hdl/lcta_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcta_back: store sequencer
// Clears the sum store after reset, then runs accumulate read-modify-write
// and query read plus divide, or an empty answer, for each queued command.
// ----------------------------------------------------------------------------
module lcta_back #(
    parameter int MAX_LABELS   = lcta_pkg::LABELS_DEF,
    parameter int MAX_CHANNELS = lcta_pkg::CHANNELS_DEF,
    parameter int MAX_CLIP_LEN = lcta_pkg::CLIP_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  lcta_pkg::cmd_ctl_t            q_ctl,
    input  logic [((MAX_LABELS*MAX_CHANNELS*MAX_CLIP_LEN) > 1 ?
                   $clog2(MAX_LABELS*MAX_CHANNELS*MAX_CLIP_LEN) : 1)-1:0] q_addr,
    input  logic [(MAX_LABELS > 1 ? $clog2(MAX_LABELS) : 1)-1:0] q_lbl,
    input  logic [lcta_pkg::SAMPLE_W-1:0] q_sample,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          done,
    output logic [lcta_pkg::MEAN_W-1:0]   mean_value,
    output logic                          empty_res
);
    import lcta_pkg::*;

    localparam int CELLS  = MAX_LABELS * MAX_CHANNELS * MAX_CLIP_LEN;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LBL_IW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

    back_state_t       state_reg, state_next;

    // current command
    cmd_ctl_t          ctl_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LBL_IW-1:0] lbl_reg;
    logic [SAMPLE_W-1:0] smp_reg;

    // sum store
    logic [SUM_W-1:0]  sum_mem [CELLS];
    logic [SUM_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [SUM_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // clip counts
    logic [CNT_W-1:0]  cnt_reg [MAX_LABELS];
    logic [CNT_W-1:0]  cnt_sel;
    logic              cnt_we;

    // adder with saturation
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_sat;

    // divider hookup
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic              div_done;
    logic [MEAN_W-1:0] div_quot;

    // result registers
    logic              done_reg, done_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic              empty_reg, empty_next;

    lcta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_sel),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cnt_sel = cnt_reg[lbl_reg];

    // sample added to the stored sum, clamped to the sum range
    assign sum_ext = {rd_data_reg[SUM_W-1], rd_data_reg} +
                     {{(SUM_W + 1 - SAMPLE_W){smp_reg[SAMPLE_W-1]}}, smp_reg};

    always_comb
    begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_ext[SUM_W-1:0];
    end

    // sequencer next state and controls
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = sum_sat;
        cnt_we        = 1'b0;
        div_start     = 1'b0;
        div_dividend  = ctl_reg.cell_ok ? rd_data_reg : '0;
        done_next     = 1'b0;
        mean_next     = mean_reg;
        empty_next    = empty_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    state_next = (q_ctl.op == OP_QUERY) ? ST_QRD : ST_ACC;
                end
            end
            ST_ACC:
            begin
                mem_we = ctl_reg.label_ok && ctl_reg.cell_ok;
                cnt_we = ctl_reg.label_ok && ctl_reg.last && (cnt_sel != '1);
                state_next = ST_IDLE;
            end
            ST_QRD:
            begin
                if (!ctl_reg.label_ok || (cnt_sel == '0))
                begin
                    done_next  = 1'b1;
                    mean_next  = '0;
                    empty_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_QDIV;
                end
            end
            ST_QDIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    mean_next  = div_quot;
                    empty_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ctl_reg  <= q_ctl;
            addr_reg <= q_addr;
            lbl_reg  <= q_lbl;
            smp_reg  <= q_sample;
        end
        mean_reg  <= mean_next;
        empty_reg <= empty_next;
    end

    // sum store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sum_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= sum_mem[q_addr];
    end

    // clip counters, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LABELS; i++)
                cnt_reg[i] <= '0;
        end
        else if (cnt_we)
        begin
            cnt_reg[lbl_reg] <= cnt_sel + CNT_W'(1);
        end
    end

    assign clearing   = (state_reg == ST_CLEAR);
    assign done       = done_reg;
    assign mean_value = mean_reg;
    assign empty_res  = empty_reg;

endmodule

FILE: hdl/labelled_clip_template_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// labelled_clip_template_averager: per-label template averaging
// Accumulate words add a sample into a per label/channel/time sum; query
// words return the sum divided by the label's clip count.
// An accepted word waits in the command queue until the store sequencer is idle.
// An accumulate then reads the store and writes the clamped sum back; a query
// reads the store, checks the count, runs 40 divider steps and registers the
// result, or gives an empty answer when the label is unusable or its count is 0.
// The sequencer handles one command at a time; the queue takes words until full.
// Reset: busy stays high while the whole sum store is cleared; the receiver
// cannot stall.
// ----------------------------------------------------------------------------
module labelled_clip_template_averager #(
    parameter int MAX_LABELS   = lcta_pkg::LABELS_DEF,
    parameter int MAX_CHANNELS = lcta_pkg::CHANNELS_DEF,
    parameter int MAX_CLIP_LEN = lcta_pkg::CLIP_LEN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [lcta_pkg::LABEL_W-1:0]          label,
    input  logic [lcta_pkg::CHANNEL_W-1:0]        channel,
    input  logic [lcta_pkg::TIME_W-1:0]           time_offset,
    input  logic signed [lcta_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  clip_last,
    output logic                                  done,
    output logic signed [lcta_pkg::MEAN_W-1:0]    mean_value,
    output logic                                  empty_res
);
    import lcta_pkg::*;

    localparam int CELLS  = MAX_LABELS * MAX_CHANNELS * MAX_CLIP_LEN;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LBL_IW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CTL_W  = $bits(cmd_ctl_t);
    localparam int WORD_W = CTL_W + ADDR_W + LBL_IW + SAMPLE_W;

    logic              keep;
    cmd_ctl_t          f_ctl;
    logic [ADDR_W-1:0] f_addr;
    logic [LBL_IW-1:0] f_lbl;
    logic              push;
    logic [WORD_W-1:0] q_din;
    logic [WORD_W-1:0] q_dout;
    logic              q_valid;
    logic              q_full;
    logic              q_pop;
    logic              clearing;
    cmd_ctl_t          b_ctl;
    logic [ADDR_W-1:0] b_addr;
    logic [LBL_IW-1:0] b_lbl;
    logic [SAMPLE_W-1:0] b_sample;
    logic [MEAN_W-1:0] mean_raw;

    // accept a word while not clearing and the queue has room
    assign busy = clearing || q_full;
    assign push = start && !busy && keep;

    lcta_front #(
        .MAX_LABELS   (MAX_LABELS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_CLIP_LEN (MAX_CLIP_LEN)
    ) u_front (
        .op          (op),
        .label       (label),
        .channel     (channel),
        .time_offset (time_offset),
        .clip_last   (clip_last),
        .keep        (keep),
        .ctl         (f_ctl),
        .addr        (f_addr),
        .lbl_idx     (f_lbl)
    );

    // pack classified word into the queue
    assign q_din = {f_ctl, f_addr, f_lbl, sample};

    lcta_fifo #(
        .DATA_W (WORD_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (q_din),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_valid),
        .full      (q_full)
    );

    // unpack queue head
    assign {b_ctl, b_addr, b_lbl, b_sample} = q_dout;

    lcta_back #(
        .MAX_LABELS   (MAX_LABELS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_CLIP_LEN (MAX_CLIP_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ctl      (b_ctl),
        .q_addr     (b_addr),
        .q_lbl      (b_lbl),
        .q_sample   (b_sample),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .done       (done),
        .mean_value (mean_raw),
        .empty_res  (empty_res)
    );

    assign mean_value = signed'(mean_raw);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the labelled clip template averager
// Sends accumulate and query words through the start/busy handshake and
// checks every done strobe against a built-in model of the sum and clip
// count stores. A short directed run covers the edge cases, then random
// clips follow, mostly well formed with random content.
// ----------------------------------------------------------------------------
module tb;

    import lcta_pkg::*;

    localparam int     CELL_COUNT     = LABELS_DEF * CHANNELS_DEF * CLIP_LEN_DEF;
    localparam longint SUM_MAX        = 64'sd549755813887;
    localparam longint SUM_MIN        = -SUM_MAX - 64'sd1;
    localparam int     COUNT_MAX      = 24'hFFFFFF;
    localparam int     RANDOM_WORDS   = 800;
    localparam int     WATCHDOG_LIMIT = 50000;
    localparam int     DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic                     empty;
    } template_answer_t;

    // model of the template stores and the queue of expected query answers
    class mean_tracker;
        longint             cell_sums [CELL_COUNT];
        int unsigned        clip_counts [LABELS_DEF];
        template_answer_t   answers [$];
        int                 errors;
        int                 acc_words;
        int                 query_words;
        int                 empty_answers;
        int                 clamped_means;

        function new();
            foreach (cell_sums[i]) cell_sums[i] = 0;
            foreach (clip_counts[i]) clip_counts[i] = 0;
        endfunction

        // apply one accepted word to the stores, queue its answer if any
        function void note_word(op_t o, logic [LABEL_W-1:0] lbl,
                                logic [CHANNEL_W-1:0] ch, logic [TIME_W-1:0] t,
                                logic signed [SAMPLE_W-1:0] smp, logic last);
            int               idx;
            bit               lbl_ok;
            longint           acc;
            longint           quot;
            template_answer_t ans;
            lbl_ok = (lbl >= 1) && (lbl <= LABELS_DEF);
            idx = 0;
            if (lbl_ok)
            begin
                idx = ((int'(lbl) - 1) * CHANNELS_DEF + int'(ch)) * CLIP_LEN_DEF + int'(t);
            end
            if (o == OP_ACC)
            begin
                acc_words++;
                if (lbl_ok)
                begin
                    // saturating add into the cell
                    acc = cell_sums[idx] + longint'(smp);
                    if (acc > SUM_MAX) acc = SUM_MAX;
                    if (acc < SUM_MIN) acc = SUM_MIN;
                    cell_sums[idx] = acc;
                    if (last && clip_counts[lbl-1] < COUNT_MAX)
                        clip_counts[lbl-1]++;
                end
            end
            else
            begin
                query_words++;
                ans.mean  = '0;
                ans.empty = 1'b1;
                if (lbl_ok && clip_counts[lbl-1] != 0)
                begin
                    // division truncates toward zero, then clamps to 16 bits
                    quot = cell_sums[idx] / longint'(clip_counts[lbl-1]);
                    if (quot > 32767 || quot < -32768) clamped_means++;
                    if (quot > 32767) quot = 32767;
                    if (quot < -32768) quot = -32768;
                    ans.mean  = quot[MEAN_W-1:0];
                    ans.empty = 1'b0;
                end
                if (ans.empty) empty_answers++;
                answers.push_back(ans);
            end
        endfunction

        // compare one done strobe with the oldest queued answer
        function void check_mean(logic signed [MEAN_W-1:0] m, logic e);
            template_answer_t want;
            if (answers.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result mean=%0d empty=%b", $time, m, e);
                return;
            end
            want = answers.pop_front();
            if (m !== want.mean || e !== want.empty)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch mean exp=%0d act=%0d, empty exp=%b act=%b",
                             $time, want.mean, m, want.empty, e);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     op;
    logic [LABEL_W-1:0]       label;
    logic [CHANNEL_W-1:0]     channel;
    logic [TIME_W-1:0]        time_offset;
    logic signed [SAMPLE_W-1:0] sample;
    logic                     clip_last;
    logic                     done;
    logic signed [MEAN_W-1:0] mean_value;
    logic                     empty_res;

    mean_tracker tracker = new();
    bit          pace_on = 1'b1;
    int          idle_cycles = 0;

    labelled_clip_template_averager dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .label       (label),
        .channel     (channel),
        .time_offset (time_offset),
        .sample      (sample),
        .clip_last   (clip_last),
        .done        (done),
        .mean_value  (mean_value),
        .empty_res   (empty_res)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            tracker.check_mean(mean_value, empty_res);
    end

    // watchdog on cycles with no handshake and no result
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // send one word, return at the edge that accepts it
    task automatic issue(input op_t o, input logic [LABEL_W-1:0] lbl,
                         input logic [CHANNEL_W-1:0] ch, input logic [TIME_W-1:0] t,
                         input logic signed [SAMPLE_W-1:0] smp, input logic last);
        int gap;
        gap = pace_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        op          <= o;
        label       <= lbl;
        channel     <= ch;
        time_offset <= t;
        sample      <= smp;
        clip_last   <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_word(o, lbl, ch, t, smp, last);
    endtask

    initial
    begin
        int                   useful;
        int                   kind;
        int                   len;
        int                   nq;
        bit                   broken;
        bit                   narrow;
        logic [LABEL_W-1:0]   lbl;
        logic [CHANNEL_W-1:0] ch;
        logic [TIME_W-1:0]    t;
        logic signed [SAMPLE_W-1:0] smp;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        op          <= OP_ACC;
        label       <= '0;
        channel     <= '0;
        time_offset <= '0;
        sample      <= '0;
        clip_last   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty labels, ignored labels, clamping, truncation
        issue(OP_QUERY, 1, 0, 0, 16'sd0, 1'b0);
        issue(OP_QUERY, 0, 7, 63, 16'sh7fff, 1'b1);
        issue(OP_ACC, 0, 1, 1, 16'sd500, 1'b1);
        issue(OP_ACC, 33, 1, 1, 16'sd500, 1'b1);
        issue(OP_ACC, 63, 7, 63, -16'sd1, 1'b1);
        issue(OP_QUERY, 63, 7, 63, 16'sd0, 1'b0);
        issue(OP_QUERY, 33, 1, 1, 16'sd0, 1'b0);
        issue(OP_ACC, 1, 0, 0, 16'sh7fff, 1'b0);
        issue(OP_ACC, 1, 0, 0, 16'sh7fff, 1'b1);
        issue(OP_QUERY, 1, 0, 0, 16'sd0, 1'b0);
        issue(OP_ACC, 32, 7, 63, 16'sh8000, 1'b0);
        issue(OP_ACC, 32, 7, 63, 16'sh8000, 1'b1);
        issue(OP_QUERY, 32, 7, 63, 16'sd0, 1'b0);
        issue(OP_QUERY, 32, 0, 0, 16'sd0, 1'b0);
        issue(OP_ACC, 2, 3, 5, -16'sd7, 1'b1);
        issue(OP_ACC, 2, 3, 5, 16'sd0, 1'b1);
        issue(OP_QUERY, 2, 3, 5, 16'sh5555, 1'b1);
        issue(OP_ACC, 2, 4, 6, 16'sd9, 1'b0);
        issue(OP_QUERY, 2, 4, 6, 16'sd0, 1'b0);
        issue(OP_QUERY, 3, 4, 6, 16'sd0, 1'b0);

        // random: mostly clips on a few labels, queries, some noise
        useful = 0;
        while (useful < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 39) == 0) pace_on = ~pace_on;
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                // one clip, occasionally missing its last mark
                lbl    = ($urandom_range(0, 3) != 0) ? LABEL_W'($urandom_range(1, 4))
                                                     : LABEL_W'($urandom_range(1, LABELS_DEF));
                len    = $urandom_range(1, 6);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++)
                begin
                    narrow = ($urandom_range(0, 3) != 0);
                    ch  = narrow ? CHANNEL_W'($urandom_range(0, 1)) : CHANNEL_W'($urandom);
                    t   = narrow ? TIME_W'($urandom_range(0, 3)) : TIME_W'($urandom);
                    smp = $urandom_range(0, 1) ? SAMPLE_W'($urandom)
                                               : SAMPLE_W'($urandom_range(0, 200) - 100);
                    issue(OP_ACC, lbl, ch, t, smp, (k == len - 1) && !broken);
                    useful++;
                end
                nq = $urandom_range(0, 3);
                for (int k = 0; k < nq; k++)
                begin
                    issue(OP_QUERY, lbl, CHANNEL_W'($urandom_range(0, 1)),
                          TIME_W'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                          1'($urandom_range(0, 1)));
                    useful++;
                end
            end
            else if (kind < 85)
            begin
                // query anywhere among valid labels
                narrow = ($urandom_range(0, 1) != 0);
                lbl = LABEL_W'($urandom_range(1, LABELS_DEF));
                ch  = narrow ? CHANNEL_W'($urandom_range(0, 1)) : CHANNEL_W'($urandom);
                t   = narrow ? TIME_W'($urandom_range(0, 3)) : TIME_W'($urandom);
                issue(OP_QUERY, lbl, ch, t, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
                useful++;
            end
            else
            begin
                // unlabelled or out-of-range label, either op
                lbl = $urandom_range(0, 1) ? LABEL_W'(0)
                                           : LABEL_W'($urandom_range(LABELS_DEF + 1, 63));
                issue($urandom_range(0, 1) ? OP_QUERY : OP_ACC, lbl, CHANNEL_W'($urandom),
                      TIME_W'($urandom), SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
            end
        end
        start <= 1'b0;

        // drain outstanding answers, then allow for the query latency
        while (tracker.answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.answers.size() != 0)
        begin
            tracker.errors += tracker.answers.size();
            $display("%0d expected results never arrived", tracker.answers.size());
        end
        $display("sent %0d accumulate and %0d query words", tracker.acc_words,
                 tracker.query_words);
        $display("answers: %0d empty, %0d clamped means; %0d errors",
                 tracker.empty_answers, tracker.clamped_means, tracker.errors);
        if (tracker.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
hdl/lcta_pkg.sv
hdl/lcta_div.sv
hdl/lcta_front.sv
hdl/lcta_fifo.sv
hdl/lcta_back.sv
hdl/labelled_clip_template_averager.sv
dv/tb.sv
